// ===== src/itt_pkg.sv =====
// Shared types and constants for the three-channel interval timer.
`timescale 1ns / 1ps

package itt_pkg;

	localparam int TIMER_COUNT_DEF      = 3;
	localparam int OUT_TOGGLE_LIMIT_DEF = 100;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_ELAPSE = 2'd2,
		KIND_BAD    = 2'd3
	} itt_kind_t;

	localparam logic [15:0] PORT_CNT0   = 16'h0040;
	localparam logic [15:0] PORT_CTRL   = 16'h0043;
	localparam logic [15:0] PORT_STATUS = 16'h0061;

	localparam logic [1:0] SEL_READBACK = 2'd3;
	localparam logic [1:0] RW_LATCH     = 2'd0;
	localparam logic [1:0] RW_LSB_MSB   = 2'd3;
	localparam logic [2:0] MODE_TC_INT  = 3'd0;
	localparam logic [2:0] MODE_RATE    = 3'd2;
	localparam logic [2:0] MODE_MAX     = 3'd5;

	// Per-channel operation strobes; at most one is set for a given beat.
	typedef struct packed {
		logic        prog;
		logic        mode2;
		logic        latch;
		logic        data_wr;
		logic        latch_rd;
		logic        elapse;
		logic        out_toggle;
		logic [7:0]  data;
		logic [15:0] clocks;
	} itt_cmd_t;

	typedef struct packed {
		logic       err;
		logic       tc;
		logic       out;
		logic [7:0] rd_byte;
	} itt_rsp_t;

endpackage

// ===== src/itt_channel.sv =====
// One 16-bit down counter of the interval timer, modes 0 and 2 only.
`timescale 1ns / 1ps

module itt_channel import itt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     gate,
	input  itt_cmd_t cmd,
	output itt_rsp_t rsp
);

	logic        mode2_q;
	logic        prog_q;
	logic        high_next_q;
	logic [7:0]  staging_q;
	logic [15:0] reload_q;
	logic [15:0] count_q;
	logic        counting_q;
	logic        out_q;
	logic        rb_full_q;
	logic        rb_high_q;
	logic [15:0] rb_value_q;

	logic [16:0] left;
	logic        expired;
	logic [16:0] remain;
	logic [15:0] load_value;

	// A zero count gets a set 17th bit, so it stands for the longest interval
	assign left       = {(count_q == 16'd0), count_q};
	assign expired    = !(left > {1'b0, cmd.clocks});
	assign remain     = left - {1'b0, cmd.clocks};
	assign load_value = {cmd.data, staging_q};

	always_comb begin
		rsp.err = (cmd.data_wr && (!prog_q ||
				(high_next_q && mode2_q && load_value == 16'd1))) ||
			(cmd.latch && rb_full_q) ||
			(cmd.latch_rd && !rb_full_q);
		rsp.tc  = cmd.elapse && counting_q && expired;
		rsp.out = out_q;
		if (cmd.latch_rd && rb_full_q) begin
			rsp.rd_byte = rb_high_q ? rb_value_q[15:8] : rb_value_q[7:0];
		end else begin
			rsp.rd_byte = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode2_q     <= 1'b0;
			prog_q      <= 1'b0;
			high_next_q <= 1'b0;
			staging_q   <= 8'd0;
			reload_q    <= 16'd0;
			count_q     <= 16'd0;
			counting_q  <= 1'b0;
			out_q       <= 1'b0;
			rb_full_q   <= 1'b0;
			rb_high_q   <= 1'b0;
			rb_value_q  <= 16'd0;
		end else if (cmd.prog) begin
			// a running count carries on under the new mode
			mode2_q     <= cmd.mode2;
			prog_q      <= 1'b1;
			staging_q   <= 8'd0;
			high_next_q <= 1'b0;
			out_q       <= cmd.mode2;
		end else if (cmd.latch) begin
			if (!rb_full_q) begin
				rb_full_q  <= 1'b1;
				rb_value_q <= count_q;
				rb_high_q  <= 1'b0;
			end
		end else if (cmd.data_wr) begin
			if (prog_q) begin
				if (!high_next_q) begin
					staging_q   <= cmd.data;
					high_next_q <= 1'b1;
				end else begin
					high_next_q <= 1'b0;
					reload_q    <= load_value;
					staging_q   <= 8'd0;
					rb_full_q   <= 1'b0;
					rb_high_q   <= 1'b0;
					if (!mode2_q) begin
						count_q    <= load_value;
						counting_q <= 1'b1;
						if (gate) begin
							out_q <= 1'b0;
						end
					end else if (load_value != 16'd1 && gate && !counting_q) begin
						count_q    <= load_value;
						counting_q <= 1'b1;
						out_q      <= 1'b1;
					end
				end
			end
		end else if (cmd.latch_rd) begin
			if (rb_full_q) begin
				if (!rb_high_q) begin
					rb_high_q <= 1'b1;
				end else begin
					rb_full_q <= 1'b0;
					rb_high_q <= 1'b0;
				end
			end
		end else if (cmd.elapse) begin
			if (counting_q) begin
				if (!expired) begin
					count_q <= remain[15:0];
				end else if (!mode2_q) begin
					count_q    <= 16'd0;
					counting_q <= 1'b0;
					out_q      <= 1'b1;
				end else begin
					count_q <= reload_q;
				end
			end
		end else if (cmd.out_toggle) begin
			out_q <= ~out_q;
		end
	end

endmodule

// ===== src/interval_timer_three_channel.sv =====
// Top level of the three-channel interval timer: bus decode, status port, beat flow.
`timescale 1ns / 1ps
// A beat is captured in the input register, then decoded and applied to the counters
//   into the result register; an output stall can hold it in the input register.
// Throughput: one beat per cycle; once both registers hold a beat, an output stall
//   stalls the input in the same cycle and holds it for as long as the stall lasts.
// Reset: arst_n clears all counter, latch, gate and status state at once; timers
//   0 and 1 have GATE tied high, timer 2 gate resets low.

module interval_timer_three_channel import itt_pkg::*; #(
	parameter int TIMER_COUNT      = TIMER_COUNT_DEF,
	parameter int OUT_TOGGLE_LIMIT = OUT_TOGGLE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] port,
	input  logic [7:0]  write_data,
	input  logic [15:0] elapsed_clocks,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        irq0_raise,
	output logic        access_error
);

	localparam int              CW      = $clog2(OUT_TOGGLE_LIMIT + 1);
	localparam logic [CW-1:0]   LIMIT_C = CW'(OUT_TOGGLE_LIMIT);
	localparam logic [1:0]      TC_C    = 2'(TIMER_COUNT);

	// Input stage
	logic        valid_s1;
	itt_kind_t   kind_s1;
	logic [15:0] port_s1;
	logic [7:0]  wd_s1;
	logic [15:0] clocks_s1;

	// Result register
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        irq_q;
	logic        err_q;

	// Shared status state
	logic          refresh_q;
	logic          speaker_q;
	logic          gate2_q;
	logic [CW-1:0] stat_cnt_q;

	logic out_free;
	logic go;

	itt_cmd_t cmd [TIMER_COUNT];
	itt_rsp_t rsp [TIMER_COUNT];

	logic       out2;
	logic       out2_toggle;
	logic       ch_err;
	logic [7:0] ch_rd;

	logic [1:0] sel;
	logic [1:0] rw;
	logic [2:0] mode;
	logic       ctrl_bad;
	logic       ctrl_latch;
	logic       ctrl_prog;
	logic       data_hit;
	logic       stat_rd;
	logic       stat_wrap;

	logic       err_d;
	logic [7:0] rd_d;
	logic       irq_d;

	// Advance a beat whenever the result register is empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign go       = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			kind_s1   <= KIND_READ;
			port_s1   <= 16'd0;
			wd_s1     <= 8'd0;
			clocks_s1 <= 16'd0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				kind_s1   <= itt_kind_t'(kind);
				port_s1   <= port;
				wd_s1     <= write_data;
				clocks_s1 <= elapsed_clocks;
			end
		end
	end

	// Control word fields
	assign sel  = wd_s1[7:6];
	assign rw   = wd_s1[5:4];
	assign mode = wd_s1[3:1];
	assign ctrl_bad = (sel == SEL_READBACK) || !(sel < TC_C) ||
		(mode > MODE_MAX) || wd_s1[0];
	assign ctrl_latch = !ctrl_bad && (rw == RW_LATCH);
	assign ctrl_prog  = !ctrl_bad && (rw == RW_LSB_MSB) &&
		(mode == MODE_TC_INT || mode == MODE_RATE);

	// Counter data ports sit at the base address plus the timer number
	assign data_hit = (port_s1[15:2] == PORT_CNT0[15:2]) && (port_s1[1:0] < TC_C);

	assign stat_rd     = kind_s1 == KIND_READ && port_s1 == PORT_STATUS;
	assign stat_wrap   = stat_cnt_q >= LIMIT_C;
	assign out2_toggle = go && stat_rd && stat_wrap;

	// Fan the beat out to the channels; strobes only fire when the beat advances
	always_comb begin
		for (int t = 0; t < TIMER_COUNT; t++) begin
			cmd[t].prog       = go && kind_s1 == KIND_WRITE && port_s1 == PORT_CTRL &&
				ctrl_prog && sel == 2'(t);
			cmd[t].mode2      = mode == MODE_RATE;
			cmd[t].latch      = go && kind_s1 == KIND_WRITE && port_s1 == PORT_CTRL &&
				ctrl_latch && sel == 2'(t);
			cmd[t].data_wr    = go && kind_s1 == KIND_WRITE && data_hit &&
				port_s1[1:0] == 2'(t);
			cmd[t].latch_rd   = go && t == 0 && kind_s1 == KIND_READ &&
				port_s1 == PORT_CNT0;
			cmd[t].elapse     = go && kind_s1 == KIND_ELAPSE;
			cmd[t].out_toggle = t == 2 && out2_toggle;
			cmd[t].data       = wd_s1;
			cmd[t].clocks     = clocks_s1;
		end
	end

	for (genvar t = 0; t < TIMER_COUNT; t++) begin : g_chan
		logic gate_t;
		if (t == 2) begin : g_gate2
			assign gate_t = gate2_q;
		end else begin : g_gate_hi
			assign gate_t = 1'b1;
		end
		itt_channel u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.gate   (gate_t),
			.cmd    (cmd[t]),
			.rsp    (rsp[t])
		);
	end

	// Timer 2 OUT: from the counter when present, a bare status bit otherwise
	if (TIMER_COUNT > 2) begin : g_out2_chan
		assign out2 = rsp[2].out;
	end else begin : g_out2_bit
		logic out2_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				out2_q <= 1'b0;
			end else if (out2_toggle) begin
				out2_q <= ~out2_q;
			end
		end
		assign out2 = out2_q;
	end

	always_comb begin
		ch_err = 1'b0;
		ch_rd  = 8'd0;
		for (int t = 0; t < TIMER_COUNT; t++) begin
			ch_err = ch_err | rsp[t].err;
			ch_rd  = ch_rd | rsp[t].rd_byte;
		end
	end

	// Result of the beat; channel errors only assert for the operation they were given
	always_comb begin
		err_d = 1'b0;
		rd_d  = 8'd0;
		irq_d = 1'b0;
		case (kind_s1)
			KIND_READ: begin
				if (port_s1 == PORT_CNT0) begin
					err_d = ch_err;
					rd_d  = ch_rd;
				end else if (port_s1 == PORT_STATUS) begin
					rd_d = {2'b00, out2 ^ stat_wrap, ~refresh_q, 2'b00, speaker_q, gate2_q};
				end else begin
					err_d = 1'b1;
				end
			end
			KIND_WRITE: begin
				if (data_hit) begin
					err_d = ch_err;
				end else if (port_s1 == PORT_CTRL) begin
					err_d = ctrl_latch ? ch_err : !ctrl_prog;
				end else if (port_s1 == PORT_STATUS) begin
					err_d = wd_s1[0] != gate2_q;
				end else begin
					err_d = 1'b1;
				end
			end
			KIND_ELAPSE: begin
				irq_d = rsp[0].tc;
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	// Status port state: refresh toggle, speaker enable, timer 2 gate, read count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q  <= 1'b0;
			speaker_q  <= 1'b0;
			gate2_q    <= 1'b0;
			stat_cnt_q <= '0;
		end else if (go) begin
			if (stat_rd) begin
				refresh_q  <= ~refresh_q;
				stat_cnt_q <= stat_wrap ? '0 : stat_cnt_q + 1'b1;
			end else if (kind_s1 == KIND_WRITE && port_s1 == PORT_STATUS) begin
				speaker_q <= wd_s1[1];
				gate2_q   <= wd_s1[0];
			end
		end
	end

	// Result register: hold while stalled, load on every advancing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			read_data_q <= 8'd0;
			irq_q       <= 1'b0;
			err_q       <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go;
			if (go) begin
				read_data_q <= rd_d;
				irq_q       <= irq_d;
				err_q       <= err_d;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign irq0_raise   = irq_q;
	assign access_error = err_q;

`ifndef SYNTHESIS
	a_irq_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(irq_q && err_q))
		else $error("irq0 raised together with an access error");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (read_data_q == 8'd0))
		else $error("failed access returned data");

	a_go_fills: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid_q)
		else $error("advanced beat did not reach the result register");

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked beat");

	a_stat_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat_cnt_q <= LIMIT_C)
		else $error("status read count beyond limit");
`endif

endmodule
